[src/dbbd_pkg.sv]
package dbbd_pkg;

   localparam int VAL_W     = 32;
   localparam int CNT_W     = 8;
   localparam int WID_W     = 6;
   localparam int BYTE_BITS = 8;
   localparam int LEFT_W    = 4;
   localparam int HDR_IDX_W = 2;

   // header byte positions
   localparam logic [HDR_IDX_W-1:0] HB_COUNT  = 2'd0;
   localparam logic [HDR_IDX_W-1:0] HB_DWIDTH = 2'd1;
   localparam logic [HDR_IDX_W-1:0] HB_FWIDTH = 2'd2;
   localparam logic [HDR_IDX_W-1:0] HB_SPARE  = 2'd3;

   localparam logic [WID_W-1:0] WID_SAT   = 6'd63;
   localparam logic [WID_W-1:0] WID_LIMIT = 6'd32;

   typedef struct packed {
      logic load;
      logic shift;
      logic flush;
   } shift_ctl_type;

   typedef struct packed {
      logic take;
      logic clear;
   } gather_ctl_type;

endpackage

[src/dbbd_byte_shifter.sv]
module dbbd_byte_shifter
   import dbbd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  shift_ctl_type        ctl,
   input  logic [BYTE_BITS-1:0] data,
   output logic                 bit_out,
   output logic [LEFT_W-1:0]    left
);

   logic [BYTE_BITS-1:0] byte_ff, byte_in;
   logic [LEFT_W-1:0]    left_ff, left_in;

   always_comb begin
      byte_in = byte_ff;
      left_in = left_ff;
      if (ctl.load) begin
         byte_in = data;
         left_in = LEFT_W'(BYTE_BITS);
      end else if (ctl.flush) begin
         left_in = '0;
      end else if (ctl.shift) begin
         byte_in = byte_ff >> 1;
         left_in = left_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      if (reset) begin
         left_ff <= '0;
      end else begin
         left_ff <= left_in;
      end
   end

   assign bit_out = byte_ff[0];
   assign left    = left_ff;

endmodule

[src/dbbd_value_gather.sv]
module dbbd_value_gather
   import dbbd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  gather_ctl_type   ctl,
   input  logic             bit_in,
   input  logic [WID_W-1:0] width,
   output logic [VAL_W-1:0] value,
   output logic             done
);

   logic [VAL_W-1:0] partial_ff, partial_in;
   logic [WID_W-1:0] gathered_ff, gathered_in;
   logic [WID_W-1:0] gathered_inc;
   logic [VAL_W-1:0] bit_mask;

   assign gathered_inc = gathered_ff + 1'b1;
   assign bit_mask     = (ctl.take && bit_in) ? (VAL_W'(1) << gathered_ff[4:0]) : '0;
   assign value        = partial_ff | bit_mask;
   assign done         = ctl.take && (gathered_inc >= width);

   always_comb begin
      partial_in  = partial_ff;
      gathered_in = gathered_ff;
      if (ctl.clear || done) begin
         partial_in  = '0;
         gathered_in = '0;
      end else if (ctl.take) begin
         partial_in  = value;
         gathered_in = gathered_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff  <= '0;
         gathered_ff <= '0;
      end else begin
         partial_ff  <= partial_in;
         gathered_ff <= gathered_in;
      end
   end

endmodule

[src/dbbd_id_store.sv]
module dbbd_id_store
   import dbbd_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int AW    = 6
)
(
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [VAL_W-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [VAL_W-1:0] rd_data
);

   logic [VAL_W-1:0] mem [DEPTH];
   logic [VAL_W-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_data = rd_ff;

endmodule

[src/delta_bitpack_block_decoder.sv]
// Delta bit-packed posting block decoder.
// Input channel req_: one byte of the encoded block per beat (req_data_byte).
// The first four bytes form the header: entry count, delta width, frequency
// width and a spare byte. Header bytes are taken without stalling req_.
// A payload byte is taken and then unpacked one bit per cycle, pausing for
// each (doc_id, frequency) pair it completes while that pair goes out, and
// longer while the output register holds (the pair is loaded from the id
// store read port). Zero-width deltas complete one per cycle without input;
// a zero-width frequency also needs no input, each pair going out as above.
// Result channel rsp_: one beat per pair, with rsp_last_of_block on the final
// pair; a bad header gives one beat with rsp_header_error set and zero fields,
// put out by the error state after the fourth header byte is taken.
// The result sits in an output register; while rsp_stall is high it holds,
// and the decoder holds too once the next result is ready, stalling req_.
// Synchronous reset returns the decoder to the header byte 0 and drops any
// pending result; the id store needs no clearing.
module delta_bitpack_block_decoder
   import dbbd_pkg::*;
#(
   parameter int MAX_DOCS = 64
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [BYTE_BITS-1:0] req_data_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [VAL_W-1:0]     rsp_doc_id,
   output logic [VAL_W-1:0]     rsp_frequency,
   output logic                 rsp_last_of_block,
   output logic                 rsp_header_error
);

   localparam int AW = (MAX_DOCS > 1) ? $clog2(MAX_DOCS) : 1;
   localparam int IW = $clog2(MAX_DOCS + 1);

   localparam logic [2:0] S_HDR  = 3'd0;
   localparam logic [2:0] S_BYTE = 3'd1;
   localparam logic [2:0] S_BITS = 3'd2;
   localparam logic [2:0] S_ZERO = 3'd3;
   localparam logic [2:0] S_PAIR = 3'd4;
   localparam logic [2:0] S_ERR  = 3'd5;

   logic [2:0]           state_ff, state_in;
   logic [HDR_IDX_W-1:0] hdr_idx_ff, hdr_idx_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [WID_W-1:0]     dw_ff, dw_in;
   logic [WID_W-1:0]     fw_ff, fw_in;
   logic                 freq_ph_ff, freq_ph_in;
   logic [IW-1:0]        idx_ff, idx_in;
   logic [VAL_W-1:0]     prev_ff, prev_in;
   logic [VAL_W-1:0]     fhold_ff, fhold_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]     rsp_id_ff, rsp_id_in;
   logic [VAL_W-1:0]     rsp_freq_ff, rsp_freq_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_err_ff, rsp_err_in;

   shift_ctl_type        sh_ctl;
   gather_ctl_type       g_ctl;
   logic                 sh_bit;
   logic [LEFT_W-1:0]    sh_left;
   logic [VAL_W-1:0]     g_value;
   logic                 g_done;
   logic [WID_W-1:0]     cur_width;

   logic                 mem_we;
   logic [VAL_W-1:0]     id_sum;
   logic [VAL_W-1:0]     rd_data;

   logic                 req_fire;
   logic                 out_free;
   logic [IW-1:0]        idx_inc;
   logic                 idx_last;
   logic                 bits_remain;
   logic                 resume;
   logic                 hdr_bad;

   assign req_fire  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign idx_inc   = idx_ff + 1'b1;
   assign idx_last  = CNT_W'(idx_inc) >= count_ff;
   assign cur_width = freq_ph_ff ? fw_ff : dw_ff;
   assign id_sum    = prev_ff + g_value;
   assign hdr_bad   = (count_ff > CNT_W'(MAX_DOCS)) || (dw_ff > WID_LIMIT)
                      || (fw_ff > WID_LIMIT);
   assign bits_remain = (state_ff == S_BITS) ? (sh_left > LEFT_W'(1)) : (sh_left != '0);
   assign req_stall = !((state_ff == S_HDR) || (state_ff == S_BYTE));

   always_comb begin
      state_in     = state_ff;
      hdr_idx_in   = hdr_idx_ff;
      count_in     = count_ff;
      dw_in        = dw_ff;
      fw_in        = fw_ff;
      freq_ph_in   = freq_ph_ff;
      idx_in       = idx_ff;
      prev_in      = prev_ff;
      fhold_in     = fhold_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_id_in    = rsp_id_ff;
      rsp_freq_in  = rsp_freq_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_err_in   = rsp_err_ff;
      sh_ctl       = '0;
      g_ctl        = '0;
      mem_we       = 1'b0;
      resume       = 1'b0;

      case (state_ff)
         S_HDR: begin
            if (req_fire) begin
               hdr_idx_in = hdr_idx_ff + 1'b1;
               case (hdr_idx_ff)
                  HB_COUNT:  count_in = req_data_byte;
                  HB_DWIDTH: dw_in = (req_data_byte > CNT_W'(WID_SAT)) ? WID_SAT
                                     : req_data_byte[WID_W-1:0];
                  HB_FWIDTH: fw_in = (req_data_byte > CNT_W'(WID_SAT)) ? WID_SAT
                                     : req_data_byte[WID_W-1:0];
                  HB_SPARE: begin
                     idx_in     = '0;
                     prev_in    = '0;
                     freq_ph_in = 1'b0;
                     g_ctl.clear  = 1'b1;
                     sh_ctl.flush = 1'b1;
                     if (count_ff == '0) begin
                        state_in = S_HDR;
                     end else if (hdr_bad) begin
                        state_in = S_ERR;
                     end else begin
                        state_in = (dw_ff == '0) ? S_ZERO : S_BYTE;
                     end
                  end
                  default: ;
               endcase
            end
         end

         S_BYTE: begin
            if (req_fire) begin
               sh_ctl.load = 1'b1;
               state_in    = S_BITS;
            end
         end

         S_BITS, S_ZERO: begin
            // zero-width values take no bit and complete at once
            if (state_ff == S_BITS) begin
               sh_ctl.shift = 1'b1;
               g_ctl.take   = 1'b1;
            end
            if (state_ff == S_ZERO || g_done) begin
               if (!freq_ph_ff) begin
                  mem_we  = 1'b1;
                  prev_in = id_sum;
                  idx_in  = idx_inc;
                  if (idx_last) begin
                     freq_ph_in = 1'b1;
                     idx_in     = '0;
                  end
                  resume = 1'b1;
               end else begin
                  fhold_in = g_value;
                  state_in = S_PAIR;
               end
            end else begin
               state_in = bits_remain ? S_BITS : S_BYTE;
            end
         end

         S_PAIR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = rd_data;
               rsp_freq_in  = fhold_ff;
               rsp_last_in  = idx_last;
               rsp_err_in   = 1'b0;
               idx_in       = idx_inc;
               if (idx_last) begin
                  // drop the padding left in the current byte
                  idx_in       = '0;
                  freq_ph_in   = 1'b0;
                  hdr_idx_in   = '0;
                  sh_ctl.flush = 1'b1;
                  state_in     = S_HDR;
               end else begin
                  resume = 1'b1;
               end
            end
         end

         S_ERR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = '0;
               rsp_freq_in  = '0;
               rsp_last_in  = 1'b0;
               rsp_err_in   = 1'b1;
               state_in     = S_HDR;
            end
         end

         default: state_in = S_HDR;
      endcase

      if (resume) begin
         if ((!freq_ph_in && dw_ff == '0) || (freq_ph_in && fw_ff == '0)) begin
            state_in = S_ZERO;
         end else if (bits_remain) begin
            state_in = S_BITS;
         end else begin
            state_in = S_BYTE;
         end
      end
   end

   always_ff @(posedge clock) begin
      prev_ff     <= prev_in;
      fhold_ff    <= fhold_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_freq_ff <= rsp_freq_in;
      rsp_last_ff <= rsp_last_in;
      rsp_err_ff  <= rsp_err_in;
      if (reset) begin
         state_ff     <= S_HDR;
         hdr_idx_ff   <= '0;
         count_ff     <= '0;
         dw_ff        <= '0;
         fw_ff        <= '0;
         freq_ph_ff   <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hdr_idx_ff   <= hdr_idx_in;
         count_ff     <= count_in;
         dw_ff        <= dw_in;
         fw_ff        <= fw_in;
         freq_ph_ff   <= freq_ph_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   dbbd_byte_shifter u_shifter (
      .clock   (clock),
      .reset   (reset),
      .ctl     (sh_ctl),
      .data    (req_data_byte),
      .bit_out (sh_bit),
      .left    (sh_left)
   );

   dbbd_value_gather u_gather (
      .clock  (clock),
      .reset  (reset),
      .ctl    (g_ctl),
      .bit_in (sh_bit),
      .width  (cur_width),
      .value  (g_value),
      .done   (g_done)
   );

   dbbd_id_store #(
      .DEPTH (MAX_DOCS),
      .AW    (AW)
   ) u_id_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (AW'(idx_ff)),
      .wr_data (id_sum),
      .rd_addr (AW'(idx_ff)),
      .rd_data (rd_data)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_doc_id        = rsp_id_ff;
   assign rsp_frequency     = rsp_freq_ff;
   assign rsp_last_of_block = rsp_last_ff;
   assign rsp_header_error  = rsp_err_ff;

endmodule

[test/posting_pair_checker.sv]
module posting_pair_checker
   import dbbd_pkg::*;
#(
   parameter int MAX_DOCS = 64
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [BYTE_BITS-1:0] req_data_byte,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [VAL_W-1:0]     rsp_doc_id,
   input  logic [VAL_W-1:0]     rsp_frequency,
   input  logic                 rsp_last_of_block,
   input  logic                 rsp_header_error,
   output int                   fail_count,
   output int                   pending_count
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   typedef enum logic [1:0] {
      DEC_HEADER,
      DEC_DELTAS,
      DEC_FREQS
   } dec_phase_type;

   typedef struct packed {
      logic [VAL_W-1:0] doc_id;
      logic [VAL_W-1:0] freq;
      logic             last;
      logic             err;
   } decoded_pair_type;

   dec_phase_type        phase_q;
   logic [HDR_IDX_W-1:0] hdr_idx;
   logic [CNT_W-1:0]     entry_count;
   logic [WID_W-1:0]     delta_width;
   logic [WID_W-1:0]     freq_width;
   logic [VAL_W-1:0]     partial;
   logic [WID_W-1:0]     bits_gathered;
   logic [6:0]           entry_idx;
   logic [VAL_W-1:0]     prev_id;
   logic [VAL_W-1:0]     id_store [64];

   decoded_pair_type expected_pairs[$];
   decoded_pair_type want;

   task automatic close_value();
      logic [VAL_W-1:0] v;
      logic [5:0]       slot;
      logic             last;
      decoded_pair_type p;
      v = partial;
      slot = entry_idx[5:0];
      partial = '0;
      bits_gathered = '0;
      if (phase_q == DEC_DELTAS) begin
         prev_id = prev_id + v;
         id_store[slot] = prev_id;
         entry_idx = entry_idx + 7'd1;
         if (entry_idx >= entry_count) begin
            phase_q = DEC_FREQS;
            entry_idx = '0;
         end
      end else if (phase_q == DEC_FREQS) begin
         last = (entry_idx + 1 >= entry_count);
         p.doc_id = id_store[slot];
         p.freq = v;
         p.last = last;
         p.err = 1'b0;
         expected_pairs.push_back(p);
         entry_idx = entry_idx + 7'd1;
         if (last) begin
            phase_q = DEC_HEADER;
            hdr_idx = HB_COUNT;
            entry_idx = '0;
         end
      end
   endtask

   // zero-width values complete as soon as they are due, without bits
   task automatic flush_empty_values();
      while ((phase_q == DEC_DELTAS && delta_width == '0) ||
             (phase_q == DEC_FREQS && freq_width == '0))
         close_value();
   endtask

   task automatic decode_byte(input logic [BYTE_BITS-1:0] b);
      decoded_pair_type p;
      if (phase_q == DEC_HEADER) begin
         case (hdr_idx)
            HB_COUNT: begin
               entry_count = b;
            end
            HB_DWIDTH: begin
               delta_width = (b > WID_SAT) ? WID_SAT : b[WID_W-1:0];
            end
            HB_FWIDTH: begin
               freq_width = (b > WID_SAT) ? WID_SAT : b[WID_W-1:0];
            end
            default: begin
            end
         endcase
         if (hdr_idx == HB_SPARE) begin
            hdr_idx = HB_COUNT;
            partial = '0;
            bits_gathered = '0;
            entry_idx = '0;
            prev_id = '0;
            if (entry_count == '0) begin
               // empty block: nothing comes out
            end else if (entry_count > MAX_DOCS || delta_width > WID_LIMIT ||
                         freq_width > WID_LIMIT) begin
               p = '0;
               p.err = 1'b1;
               expected_pairs.push_back(p);
            end else begin
               phase_q = DEC_DELTAS;
               flush_empty_values();
            end
         end else begin
            hdr_idx = hdr_idx + 2'd1;
         end
      end else begin
         for (int k = 0; k < BYTE_BITS; k++) begin
            // drop padding once the block is done
            if (phase_q != DEC_HEADER) begin
               if (b[k])
                  partial[bits_gathered[4:0]] = 1'b1;
               bits_gathered = bits_gathered + 6'd1;
               if (bits_gathered >= ((phase_q == DEC_DELTAS) ? delta_width : freq_width)) begin
                  close_value();
                  flush_empty_values();
               end
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         phase_q = DEC_HEADER;
         hdr_idx = HB_COUNT;
         entry_count = '0;
         delta_width = '0;
         freq_width = '0;
         partial = '0;
         bits_gathered = '0;
         entry_idx = '0;
         prev_id = '0;
         for (int i = 0; i < 64; i++)
            id_store[i] = '0;
         expected_pairs.delete();
      end else begin
         // check the result beat before the byte beat: no byte answers in its own cycle
         if (rsp_valid && !rsp_stall) begin
            if (expected_pairs.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("unexpected beat: doc_id %h freq %h last %0b err %0b",
                           rsp_doc_id, rsp_frequency, rsp_last_of_block, rsp_header_error);
            end else begin
               want = expected_pairs.pop_front();
               if (rsp_doc_id !== want.doc_id || rsp_frequency !== want.freq ||
                   rsp_last_of_block !== want.last || rsp_header_error !== want.err) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT)
                     $display("mismatch: exp doc_id %h freq %h last %0b err %0b / %s",
                              want.doc_id, want.freq, want.last, want.err,
                              $sformatf("got doc_id %h freq %h last %0b err %0b",
                                        rsp_doc_id, rsp_frequency, rsp_last_of_block,
                                        rsp_header_error));
               end
            end
         end
         if (req_valid && !req_stall)
            decode_byte(req_data_byte);
      end
      pending_count <= expected_pairs.size();
   end

endmodule

[test/tb_top.sv]
module tb_top
   import dbbd_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_DOCS     = 64;
   localparam int BYTE_TARGET  = 430;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 200;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_COIN,
      STALL_PERIODIC,
      STALL_HEAVY
   } stall_mode_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [BYTE_BITS-1:0] req_data_byte = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [VAL_W-1:0]     rsp_doc_id;
   logic [VAL_W-1:0]     rsp_frequency;
   logic                 rsp_last_of_block;
   logic                 rsp_header_error;

   int             fail_count;
   int             pending_count;
   int unsigned    cycle_count = 0;
   int             bytes_sent = 0;
   int             burst_left = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int             stall_left = 0;

   delta_bitpack_block_decoder #(
      .MAX_DOCS(MAX_DOCS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_doc_id(rsp_doc_id),
      .rsp_frequency(rsp_frequency),
      .rsp_last_of_block(rsp_last_of_block),
      .rsp_header_error(rsp_header_error)
   );

   posting_pair_checker #(
      .MAX_DOCS(MAX_DOCS)
   ) checker_i (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_doc_id(rsp_doc_id),
      .rsp_frequency(rsp_frequency),
      .rsp_last_of_block(rsp_last_of_block),
      .rsp_header_error(rsp_header_error),
      .fail_count(fail_count),
      .pending_count(pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // receiver back-pressure: switch between stall patterns every so often
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_left <= $urandom_range(20, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         STALL_NONE:     rsp_stall <= 1'b0;
         STALL_COIN:     rsp_stall <= ($urandom_range(0, 1) == 1);
         STALL_PERIODIC: rsp_stall <= ((stall_left % 3) == 0);
         default:        rsp_stall <= ($urandom_range(0, 4) != 0);
      endcase
   end

   task automatic send_byte(input logic [BYTE_BITS-1:0] b);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 99) < 40) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      burst_left--;
   endtask

   task automatic send_header(input logic [7:0] count, input logic [7:0] dwidth,
                              input logic [7:0] fwidth, input logic [7:0] spare);
      send_byte(count);
      send_byte(dwidth);
      send_byte(fwidth);
      send_byte(spare);
   endtask

   function automatic int pick_width(input int wmax);
      int r;
      r = $urandom_range(0, 99);
      if (r < 20)
         return 0;
      if (r < 30)
         return wmax;
      if (r < 70)
         return $urandom_range(1, (wmax < 8) ? wmax : 8);
      return $urandom_range(1, wmax);
   endfunction

   task automatic send_block();
      int pick;
      int r;
      int count;
      int dw;
      int fw;
      int nbytes;
      logic [7:0] spare;
      pick = $urandom_range(0, 99);
      spare = 8'($urandom);
      if (pick < 13) begin
         // random header bytes, mostly out of range
         repeat (4) send_byte(8'($urandom));
         bytes_sent += 4;
      end else if (pick < 25) begin
         case ($urandom_range(0, 2))
            0: send_header(8'($urandom_range(MAX_DOCS + 1, 255)), 8'(pick_width(32)),
                           8'(pick_width(32)), spare);
            1: send_header(8'($urandom_range(1, MAX_DOCS)), 8'($urandom_range(33, 255)),
                           8'(pick_width(32)), spare);
            default: send_header(8'($urandom_range(1, MAX_DOCS)), 8'(pick_width(32)),
                                 8'($urandom_range(33, 255)), spare);
         endcase
         bytes_sent += 4;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 5)
            count = 0;
         else if (r < 60)
            count = $urandom_range(1, 8);
         else if (r < 85)
            count = $urandom_range(9, 20);
         else if (r < 93)
            count = $urandom_range(21, MAX_DOCS - 1);
         else
            count = MAX_DOCS;
         // keep long blocks narrow so they stay cheap
         dw = pick_width((count > 16) ? 4 : 32);
         fw = pick_width((count > 16) ? 4 : 32);
         nbytes = (count * (dw + fw) + 7) / 8;
         send_header(8'(count), 8'(dw), 8'(fw), spare);
         for (int i = 0; i < nbytes; i++) begin
            r = $urandom_range(0, 99);
            send_byte((r < 10) ? 8'h00 : (r < 20) ? 8'hff : 8'($urandom));
         end
         bytes_sent += 4 + nbytes;
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty block, spare byte all ones
      send_header(8'h00, 8'h00, 8'h00, 8'hff);
      // count one past the limit
      send_header(8'(MAX_DOCS + 1), 8'h00, 8'h00, 8'h00);
      // delta width 33 and a saturated frequency width
      send_header(8'h01, 8'h21, 8'hff, 8'h00);
      // all zero widths: both pairs come out with the header
      send_header(8'h02, 8'h00, 8'h00, 8'h00);
      // full-width delta of all ones, zero-width frequency
      send_header(8'h01, 8'h20, 8'h00, 8'h00);
      repeat (4) send_byte(8'hff);

      while (bytes_sent < BYTE_TARGET)
         send_block();
      req_valid <= 1'b0;

      // let the count pick up the last byte's predictions
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && pending_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

[delta_bitpack_block_decoder.f]
src/dbbd_pkg.sv
src/dbbd_byte_shifter.sv
src/dbbd_value_gather.sv
src/dbbd_id_store.sv
src/delta_bitpack_block_decoder.sv
test/posting_pair_checker.sv
test/tb_top.sv
